// File: hw/rtl/pgu_pkg.sv
// ----------------------------------------------------------------------------
// pgu_pkg
// Shared widths, constants, types and helper functions of the pixel to
// glyph unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pgu_pkg;

  // pixel and gain formats
  localparam int CH_W       = 8;
  localparam int GAIN_W     = 12;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 12'd384;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_ENABLE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SATURATION_GAIN = 1'd1;

  // brightness weights, Q0.16
  localparam logic [15:0] P_W_R = 16'd19595;
  localparam logic [15:0] P_W_G = 16'd38470;
  localparam logic [15:0] P_W_B = 16'd7471;

  // luma weights, Q0.16
  localparam int unsigned LUMA_W_R = 13933;
  localparam int unsigned LUMA_W_G = 46871;
  localparam int unsigned LUMA_W_B = 4732;
  localparam int LUMA_SHIFT = 28;

  // square root: 24-bit radicand, 12-bit root, two root bits per stage
  localparam int RAD_W               = 24;
  localparam int ROOT_W              = 12;
  localparam int REM_W               = 14;
  localparam int SQRT_STEPS_PER_STAGE = 2;
  localparam int SQRT_STAGES         = ROOT_W / SQRT_STEPS_PER_STAGE;

  // saturation arithmetic
  localparam int DIFF_W  = 13;
  localparam int PROD_W  = DIFF_W + GAIN_W + 1;
  localparam int CLAMP_W = 20;
  localparam logic [CLAMP_W-1:0] FULL_CH = 20'd1044480;

  // glyph table
  localparam int GLYPH_COUNT_DEF = 30;
  localparam int ROM_IDX_W       = 6;
  localparam int GLYPH_W         = 7;
  localparam int GLYPH_TABLE_LEN = 30;
  localparam logic [GLYPH_W-1:0] GLYPH_SPACE = 7'd32;
  localparam logic [GLYPH_W-1:0] GLYPH_TABLE [0:GLYPH_TABLE_LEN-1] = '{
    7'd78, 7'd64, 7'd35, 7'd87, 7'd36, 7'd57, 7'd56, 7'd55, 7'd54, 7'd53,
    7'd52, 7'd51, 7'd50, 7'd49, 7'd48, 7'd63, 7'd33, 7'd97, 7'd98, 7'd99,
    7'd59, 7'd58, 7'd43, 7'd61, 7'd45, 7'd95, 7'd44, 7'd46, 7'd32, 7'd32
  };

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            row_end;
  } pix_t;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_state_t;

  // c*16 - p, both with four fraction bits
  function automatic logic signed [DIFF_W-1:0] sat_diff(input logic [CH_W-1:0] c,
                                                        input logic [ROOT_W-1:0] p4);
    sat_diff = $signed({1'b0, c, 4'b0000}) - $signed({1'b0, p4});
  endfunction

  // p*256 + product, clamped to 0..255.0 in Q8.12
  function automatic logic [CLAMP_W-1:0] sat_clamp(input logic [ROOT_W-1:0] p4,
                                                   input logic signed [PROD_W-1:0] prod);
    logic signed [PROD_W:0] v;
    v = $signed({(PROD_W + 1 - ROOT_W - 8)'(0), p4, 8'h00}) + (PROD_W + 1)'(prod);
    if (v < 0) begin
      sat_clamp = '0;
    end else if (v > $signed({(PROD_W + 1 - CLAMP_W)'(0), FULL_CH})) begin
      sat_clamp = FULL_CH;
    end else begin
      sat_clamp = v[CLAMP_W-1:0];
    end
  endfunction

  // entries past the table read as space
  function automatic logic [GLYPH_W-1:0] glyph_lookup(input logic [ROM_IDX_W-1:0] idx);
    if (idx < ROM_IDX_W'(GLYPH_TABLE_LEN)) begin
      glyph_lookup = GLYPH_TABLE[idx[4:0]];
    end else begin
      glyph_lookup = GLYPH_SPACE;
    end
  endfunction

endpackage

// File: hw/rtl/pgu_isqrt_stage.sv
// ----------------------------------------------------------------------------
// pgu_isqrt_stage
// One register stage of the pipelined integer square root: resolves two
// root bits by restoring trial subtraction and carries the pixel along.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pgu_isqrt_stage
  import pgu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        valid_in,
  input  sqrt_state_t state_in,
  input  pix_t        pix_in,
  output logic        valid,
  output sqrt_state_t state,
  output pix_t        pix
);

  sqrt_state_t state_next;

  always_comb begin
    logic [REM_W+1:0] rem_w;
    logic [REM_W+1:0] trial;
    state_next = state_in;
    for (int k = 0; k < SQRT_STEPS_PER_STAGE; k++) begin
      rem_w = {state_next.rem, state_next.rad[RAD_W-1 -: 2]};
      trial = (REM_W + 2)'({state_next.root, 2'b01});
      if (rem_w >= trial) begin
        state_next.rem  = REM_W'(rem_w - trial);
        state_next.root = {state_next.root[ROOT_W-2:0], 1'b1};
      end else begin
        state_next.rem  = REM_W'(rem_w);
        state_next.root = {state_next.root[ROOT_W-2:0], 1'b0};
      end
      state_next.rad = state_next.rad << 2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      state <= state_next;
      pix   <= pix_in;
    end
  end

endmodule

// File: hw/rtl/pixel_saturate_to_ascii_glyph_unit.sv
// ----------------------------------------------------------------------------
// pixel_saturate_to_ascii_glyph_unit
// Maps RGB pixels to a saturation-boosted colour and an ASCII glyph chosen
// by luma, one pixel every cycle while the output register is free or being
// drained. The pipeline holds the squaring, weighting and sum stages, the
// 6-stage square root of the brightness (two root bits per stage) and the
// multiply, clamp, luma, luma sum and output stages. All stages advance
// together: when a result sits in the output register and is not taken,
// the whole pipeline holds and in_ready drops. Configuration writes take
// effect at once and are meant to happen while no pixel is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pixel_saturate_to_ascii_glyph_unit
  import pgu_pkg::*;
#(
  parameter int GLYPH_COUNT = GLYPH_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // pixel in
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CH_W-1:0]       red_in,
  input  logic [CH_W-1:0]       green_in,
  input  logic [CH_W-1:0]       blue_in,
  input  logic                  row_end_in,
  // result out
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [GLYPH_W-1:0]    glyph_code,
  output logic [CH_W-1:0]       red_out,
  output logic [CH_W-1:0]       green_out,
  output logic [CH_W-1:0]       blue_out,
  output logic                  color_on,
  output logic                  row_end_out
);

  // luma weights pre-scaled by the glyph step count
  localparam int unsigned LW_R = LUMA_W_R * (GLYPH_COUNT - 1);
  localparam int unsigned LW_G = LUMA_W_G * (GLYPH_COUNT - 1);
  localparam int unsigned LW_B = LUMA_W_B * (GLYPH_COUNT - 1);
  localparam int LW_W    = $clog2(LW_G + 1);
  localparam int LUMA_PW = CLAMP_W + LW_W;
  localparam int LSUM_W  = LUMA_PW + 2;
  localparam int TW      = LSUM_W - LUMA_SHIFT;
  localparam int QT      = TW + 1;
  localparam int QW      = QT - 8;

  // ---------------- configuration registers ----------------
  logic              color_enable;
  logic [GAIN_W-1:0] saturation_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_enable    <= 1'b0;
      saturation_gain <= GAIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COLOR_ENABLE:    color_enable    <= cfg_data[0];
        CFG_SATURATION_GAIN: saturation_gain <= cfg_data[GAIN_W-1:0];
      endcase
    end
  end

  // whole pipeline moves when the output register is free or being drained
  logic adv;
  assign adv      = ~out_valid | out_ready;
  assign in_ready = adv;

  // ---------------- stage 1: squares ----------------
  logic        s1_valid;
  pix_t        s1_pix;
  logic [15:0] s1_sq_r, s1_sq_g, s1_sq_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pix  <= '{red: red_in, green: green_in, blue: blue_in, row_end: row_end_in};
      s1_sq_r <= 16'(red_in) * 16'(red_in);
      s1_sq_g <= 16'(green_in) * 16'(green_in);
      s1_sq_b <= 16'(blue_in) * 16'(blue_in);
    end
  end

  // ---------------- stage 2: weighted squares ----------------
  logic        s2_valid;
  pix_t        s2_pix;
  logic [31:0] s2_wr, s2_wg, s2_wb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_pix <= s1_pix;
      s2_wr  <= 32'(s1_sq_r) * 32'(P_W_R);
      s2_wg  <= 32'(s1_sq_g) * 32'(P_W_G);
      s2_wb  <= 32'(s1_sq_b) * 32'(P_W_B);
    end
  end

  // ---------------- stage 3: sum, square root setup ----------------
  logic        sq_valid [0:SQRT_STAGES];
  sqrt_state_t sq_state [0:SQRT_STAGES];
  pix_t        sq_pix   [0:SQRT_STAGES];
  logic [32:0] wsum;

  assign wsum = 33'(s2_wr) + 33'(s2_wg) + 33'(s2_wb);

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid[0] <= 1'b0;
    end else if (adv) begin
      sq_valid[0] <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_pix[0]   <= s2_pix;
      sq_state[0] <= '{rad: wsum[31:8], rem: '0, root: '0};
    end
  end

  // ---------------- square root pipeline ----------------
  for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_sqrt
    pgu_isqrt_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .valid_in (sq_valid[i]),
      .state_in (sq_state[i]),
      .pix_in   (sq_pix[i]),
      .valid    (sq_valid[i+1]),
      .state    (sq_state[i+1]),
      .pix      (sq_pix[i+1])
    );
  end

  // ---------------- saturation products ----------------
  logic                     m_valid;
  logic                     m_row_end;
  logic [ROOT_W-1:0]        m_p4;
  logic signed [PROD_W-1:0] m_prod_r, m_prod_g, m_prod_b;
  logic [ROOT_W-1:0]        p4;
  logic signed [GAIN_W:0]   gain_s;

  assign p4     = sq_state[SQRT_STAGES].root;
  assign gain_s = $signed({1'b0, saturation_gain});

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (adv) begin
      m_valid <= sq_valid[SQRT_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_row_end <= sq_pix[SQRT_STAGES].row_end;
      m_p4      <= p4;
      m_prod_r  <= sat_diff(sq_pix[SQRT_STAGES].red, p4) * gain_s;
      m_prod_g  <= sat_diff(sq_pix[SQRT_STAGES].green, p4) * gain_s;
      m_prod_b  <= sat_diff(sq_pix[SQRT_STAGES].blue, p4) * gain_s;
    end
  end

  // ---------------- add brightness and clamp ----------------
  logic               c_valid;
  logic               c_row_end;
  logic [CLAMP_W-1:0] c_rc, c_gc, c_bc;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_row_end <= m_row_end;
      c_rc      <= sat_clamp(m_p4, m_prod_r);
      c_gc      <= sat_clamp(m_p4, m_prod_g);
      c_bc      <= sat_clamp(m_p4, m_prod_b);
    end
  end

  // ---------------- luma products ----------------
  logic               l_valid;
  logic               l_row_end;
  logic [CH_W-1:0]    l_red, l_green, l_blue;
  logic [LUMA_PW-1:0] l_lr, l_lg, l_lb;

  always_ff @(posedge clk) begin
    if (rst) begin
      l_valid <= 1'b0;
    end else if (adv) begin
      l_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l_row_end <= c_row_end;
      l_red     <= c_rc[CLAMP_W-1 -: CH_W];
      l_green   <= c_gc[CLAMP_W-1 -: CH_W];
      l_blue    <= c_bc[CLAMP_W-1 -: CH_W];
      l_lr      <= LUMA_PW'(c_rc) * LUMA_PW'(LW_R);
      l_lg      <= LUMA_PW'(c_gc) * LUMA_PW'(LW_G);
      l_lb      <= LUMA_PW'(c_bc) * LUMA_PW'(LW_B);
    end
  end

  // ---------------- luma sum, scaled ----------------
  logic              t_valid;
  logic              t_row_end;
  logic [CH_W-1:0]   t_red, t_green, t_blue;
  logic [TW-1:0]     t_val;
  logic [LSUM_W-1:0] lsum;

  assign lsum = LSUM_W'(l_lr) + LSUM_W'(l_lg) + LSUM_W'(l_lb);

  always_ff @(posedge clk) begin
    if (rst) begin
      t_valid <= 1'b0;
    end else if (adv) begin
      t_valid <= l_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t_row_end <= l_row_end;
      t_red     <= l_red;
      t_green   <= l_green;
      t_blue    <= l_blue;
      t_val     <= lsum[LSUM_W-1:LUMA_SHIFT];
    end
  end

  // ---------------- divide by 255, glyph lookup, output register ----------------
  logic [QT-1:0] t_adj;
  logic [QW-1:0] q;

  // floor(t / 255) = (t + (t >> 8) + 1) >> 8 while the quotient stays below 256
  always_comb begin
    t_adj = QT'(t_val) + QT'(t_val >> 8) + QT'(1);
    q     = t_adj[QT-1:8];
    if (q > QW'(GLYPH_COUNT - 1)) begin
      q = QW'(GLYPH_COUNT - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= t_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      glyph_code  <= glyph_lookup(ROM_IDX_W'(q));
      red_out     <= t_red;
      green_out   <= t_green;
      blue_out    <= t_blue;
      color_on    <= color_enable;
      row_end_out <= t_row_end;
    end
  end

endmodule

// File: hw/rtl/pgu_port_checker.sv
// ----------------------------------------------------------------------------
// pgu_port_checker
// Port-level checks of the pixel to glyph unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pgu_port_checker
  import pgu_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [GLYPH_W-1:0]    glyph_code,
  input logic [CH_W-1:0]       red_out,
  input logic [CH_W-1:0]       green_out,
  input logic [CH_W-1:0]       blue_out,
  input logic                  color_on,
  input logic                  row_end_out
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(glyph_code) && $stable(red_out) &&
      $stable(green_out) && $stable(blue_out) && $stable(color_on) &&
      $stable(row_end_out))
    else $error("result payload changed while stalled");

  // an empty output register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // glyphs are printable characters
  a_glyph_printable: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (glyph_code >= 7'd32) && (glyph_code <= 7'd126))
    else $error("glyph code out of printable range");

  // nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result offered after reset");

endmodule

bind pixel_saturate_to_ascii_glyph_unit pgu_port_checker u_port_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .glyph_code  (glyph_code),
  .red_out     (red_out),
  .green_out   (green_out),
  .blue_out    (blue_out),
  .color_on    (color_on),
  .row_end_out (row_end_out)
);
